// ===== hw/rtl/htba_pkg.sv =====
package htba_pkg;

    localparam int SLOT_FIELD_W = 16;

    localparam logic [16:0] HOUR_SECS = 17'd3600;
    localparam logic [16:0] DAY_SECS  = 17'd86400;

    // bucket width splits into an odd factor and a power of two
    localparam int          HOUR_SHIFT = 4;
    localparam int          DAY_SHIFT  = 7;
    localparam logic [9:0]  HOUR_ODD   = 10'(HOUR_SECS >> HOUR_SHIFT);
    localparam logic [9:0]  DAY_ODD    = 10'(DAY_SECS >> DAY_SHIFT);

    // weight of each 12-bit chunk modulo the odd factor
    localparam logic [9:0]  HOUR_P1 = 10'((64'd1 << 12) % 64'(HOUR_ODD));
    localparam logic [9:0]  HOUR_P2 = 10'((64'd1 << 24) % 64'(HOUR_ODD));
    localparam logic [9:0]  HOUR_P3 = 10'((64'd1 << 36) % 64'(HOUR_ODD));
    localparam logic [9:0]  HOUR_P4 = 10'((64'd1 << 48) % 64'(HOUR_ODD));
    localparam logic [9:0]  DAY_P1  = 10'((64'd1 << 12) % 64'(DAY_ODD));
    localparam logic [9:0]  DAY_P2  = 10'((64'd1 << 24) % 64'(DAY_ODD));
    localparam logic [9:0]  DAY_P3  = 10'((64'd1 << 36) % 64'(DAY_ODD));
    localparam logic [9:0]  DAY_P4  = 10'((64'd1 << 48) % 64'(DAY_ODD));

    // rounded-up reciprocal, exact for folded values below 2^24
    localparam int          RECIP_SHIFT = 34;
    localparam logic [26:0] HOUR_RECIP  =
        27'(((64'd1 << RECIP_SHIFT) + 64'(HOUR_ODD) - 64'd1) / 64'(HOUR_ODD));
    localparam logic [26:0] DAY_RECIP   =
        27'(((64'd1 << RECIP_SHIFT) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    localparam logic [31:0] FILES_MAX = 32'hffffffff;

    localparam logic [1:0] CFG_INTERVAL_MODE = 2'd0;
    localparam logic [1:0] CFG_CUTOFF_TIME   = 2'd1;

    typedef enum logic [1:0] {
        STATUS_FILTERED = 2'd0,
        STATUS_HIT      = 2'd1,
        STATUS_NEW      = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [62:0] stamp;
        logic [63:0] file_size;
    } rec_in_t;

    typedef struct packed {
        status_t     status;
        logic [6:0]  bucket_index;
        logic [62:0] bucket_start;
        logic [63:0] bucket_bytes;
        logic [31:0] bucket_files;
        logic [63:0] grand_bytes;
        logic [31:0] grand_files;
        logic        full_seen;
    } rec_out_t;

    // classified request passed from the front to the back
    typedef struct packed {
        logic                    filtered;
        logic [62:0]             start;
        logic [63:0]             size;
        logic [SLOT_FIELD_W-1:0] slot;
    } work_t;

    typedef struct packed {
        logic push;
    } qctl_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_FOLD,
        F_QUOT,
        F_SUB,
        F_MIX1,
        F_MUL1,
        F_MIX2,
        F_MUL2,
        F_FIN,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_ENTRY,
        B_CMP,
        B_MISS,
        B_OUT
    } back_state_t;

endpackage

// ===== hw/rtl/htba_front.sv =====
module htba_front
    import htba_pkg::*;
#(
    parameter int SLOTS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        interval_mode,
    input  logic [62:0] cutoff,
    input  logic        in_valid,
    output logic        in_ready,
    input  rec_in_t     in_data,
    input  logic        q_full,
    output qctl_t       qctl,
    output work_t       work
);

    localparam logic [63:0] SLOT_MASK = 64'(SLOTS - 1);

    front_state_t state_reg, state_next;
    logic [62:0]  t_reg, t_next;
    logic [63:0]  size_reg, size_next;
    logic         filt_reg, filt_next;
    logic [23:0]  fold_reg, fold_next;
    logic [16:0]  quot_reg, quot_next;
    logic [63:0]  x_reg, x_next;
    logic [63:0]  acc_reg, acc_next;
    logic [63:0]  prod_reg, prod_next;
    logic [1:0]   ms_reg, ms_next;

    logic         filt_in;
    logic [59:0]  scaled;
    logic [9:0]   odd;
    logic [9:0]   p1;
    logic [9:0]   p2;
    logic [9:0]   p3;
    logic [9:0]   p4;
    logic [26:0]  recip;
    logic [23:0]  fold_sum;
    logic [9:0]   rem;
    logic [62:0]  start_calc;
    logic [63:0]  mul_const;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;

    assign filt_in    = (cutoff != 63'd0) && (in_data.stamp < cutoff);
    assign scaled     = interval_mode ? 60'(t_reg[62:DAY_SHIFT]) : 60'(t_reg[62:HOUR_SHIFT]);
    assign odd        = interval_mode ? DAY_ODD : HOUR_ODD;
    assign p1         = interval_mode ? DAY_P1 : HOUR_P1;
    assign p2         = interval_mode ? DAY_P2 : HOUR_P2;
    assign p3         = interval_mode ? DAY_P3 : HOUR_P3;
    assign p4         = interval_mode ? DAY_P4 : HOUR_P4;
    assign recip      = interval_mode ? DAY_RECIP : HOUR_RECIP;
    // fold 12-bit chunks into a value congruent modulo the odd factor
    assign fold_sum   = 24'(scaled[11:0]) + 24'(scaled[23:12]) * 24'(p1)
                        + 24'(scaled[35:24]) * 24'(p2) + 24'(scaled[47:36]) * 24'(p3)
                        + 24'(scaled[59:48]) * 24'(p4);
    assign rem        = 10'(fold_reg - 24'(quot_reg) * 24'(odd));
    assign start_calc = interval_mode
                        ? {t_reg[62:DAY_SHIFT] - 56'(rem), 7'd0}
                        : {t_reg[62:HOUR_SHIFT] - 59'(rem), 4'd0};
    assign mul_const  = (state_reg == F_MUL2) ? MIX_C2 : MIX_C1;
    assign mul_a      = (ms_reg == 2'd1) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b      = (ms_reg == 2'd2) ? mul_const[63:32] : mul_const[31:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = filt_in ? F_PUSH : F_FOLD;
                end
            end
            F_FOLD: state_next = F_QUOT;
            F_QUOT: state_next = F_SUB;
            F_SUB:  state_next = F_MIX1;
            F_MIX1: state_next = F_MUL1;
            F_MUL1:
            begin
                if (ms_reg == 2'd3)
                begin
                    state_next = F_MIX2;
                end
            end
            F_MIX2: state_next = F_MUL2;
            F_MUL2:
            begin
                if (ms_reg == 2'd3)
                begin
                    state_next = F_FIN;
                end
            end
            F_FIN:  state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == F_IDLE);
        qctl.push     = (state_reg == F_PUSH) && !q_full;
        work.filtered = filt_reg;
        work.start    = t_reg;
        work.size     = size_reg;
        work.slot     = SLOT_FIELD_W'(x_reg & SLOT_MASK);
    end

    always_comb
    begin
        t_next    = t_reg;
        size_next = size_reg;
        filt_next = filt_reg;
        fold_next = fold_reg;
        quot_next = quot_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        prod_next = 64'(mul_a) * 64'(mul_b);
        ms_next   = ms_reg;
        case (state_reg)
            F_IDLE:
            begin
                t_next    = in_data.stamp;
                size_next = in_data.file_size;
                filt_next = filt_in;
            end
            F_FOLD:
            begin
                fold_next = fold_sum;
            end
            F_QUOT:
            begin
                quot_next = 17'((51'(fold_reg) * 51'(recip)) >> RECIP_SHIFT);
            end
            F_SUB:
            begin
                t_next = start_calc;
                x_next = {1'b0, start_calc};
            end
            F_MIX1:
            begin
                x_next  = x_reg ^ (x_reg >> 30);
                ms_next = 2'd0;
            end
            F_MIX2:
            begin
                x_next  = x_reg ^ (x_reg >> 27);
                ms_next = 2'd0;
            end
            F_MUL1, F_MUL2:
            begin
                // 64x64 low half from three 32x32 partial products
                ms_next = ms_reg + 2'd1;
                case (ms_reg)
                    2'd1: acc_next = prod_reg;
                    2'd2: acc_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                    2'd3: x_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                    default: acc_next = acc_reg;
                endcase
            end
            F_FIN:
            begin
                x_next = x_reg ^ (x_reg >> 31);
            end
            default:
            begin
                t_next = t_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        size_reg <= size_next;
        filt_reg <= filt_next;
        fold_reg <= fold_next;
        quot_reg <= quot_next;
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        ms_reg   <= ms_next;
    end

endmodule

// ===== hw/rtl/htba_queue.sv =====
module htba_queue
    import htba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  qctl_t qctl,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output work_t pop_data,
    output logic  empty
);

    work_t      ent_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = ent_reg[rp_reg];

    always_comb
    begin
        wp_next  = qctl.push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, qctl.push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (qctl.push)
        begin
            ent_reg[wp_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/htba_back.sv =====
module htba_back
    import htba_pkg::*;
#(
    parameter int SLOTS   = 256,
    parameter int BUCKETS = 128
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  work_t    q_data,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output rec_out_t out_data
);

    localparam int SW         = $clog2(SLOTS);
    localparam int NW         = $clog2(SLOTS + 1);
    localparam int EW         = $clog2(BUCKETS + 1);
    localparam int BW         = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int LOAD_LIMIT = (SLOTS / 4) * 3;

    back_state_t state_reg, state_next;
    logic [SW-1:0] clr_reg, clr_next;
    work_t         w_reg, w_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [NW-1:0] n_reg, n_next;
    logic          have_empty_reg, have_empty_next;
    logic [SW-1:0] empty_reg, empty_next;
    logic [BW-1:0] bi_reg, bi_next;
    logic [EW-1:0] used_reg, used_next;
    logic [63:0]   tbytes_reg, tbytes_next;
    logic [31:0]   tfiles_reg, tfiles_next;
    logic          full_reg, full_next;
    rec_out_t      res_reg, res_next;

    logic [EW-1:0] slot_mem [SLOTS];
    logic [62:0]   start_mem [BUCKETS];
    logic [63:0]   bytes_mem [BUCKETS];
    logic [31:0]   files_mem [BUCKETS];

    logic [EW-1:0] slot_q;
    logic [62:0]   start_q;
    logic [63:0]   bytes_q;
    logic [31:0]   files_q;

    logic          slot_we;
    logic [SW-1:0] slot_wa;
    logic [EW-1:0] slot_wd;
    logic          bkt_we;
    logic [BW-1:0] bkt_wa;
    logic [62:0]   start_wd;
    logic [63:0]   bytes_wd;
    logic [31:0]   files_wd;
    logic [BW-1:0] rd_bi;

    logic [EW-1:0] ent_m1;
    logic          ent_ok;
    logic          start_eq;
    logic [NW-1:0] n_inc;
    logic          probe_done;
    logic [SW-1:0] slot_inc;
    logic          no_room;
    logic [63:0]   hit_bytes;
    logic [31:0]   hit_files;
    logic [31:0]   tfiles_inc;

    assign ent_m1     = slot_q - EW'(1);
    assign ent_ok     = (ent_m1 < used_reg);
    assign rd_bi      = BW'(ent_m1);
    assign start_eq   = (start_q == w_reg.start);
    assign n_inc      = n_reg + NW'(1);
    assign probe_done = (n_inc == NW'(SLOTS));
    assign slot_inc   = (slot_reg == SW'(SLOTS - 1)) ? SW'(0) : slot_reg + SW'(1);
    assign no_room    = (32'(used_reg) >= 32'(BUCKETS)) || (32'(used_reg) >= 32'(LOAD_LIMIT))
                        || !have_empty_reg;
    assign hit_bytes  = bytes_q + w_reg.size;
    assign hit_files  = (files_q == FILES_MAX) ? files_q : files_q + 32'd1;
    assign tfiles_inc = (tfiles_reg == FILES_MAX) ? tfiles_reg : tfiles_reg + 32'd1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_reg == SW'(SLOTS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_data.filtered ? B_OUT : B_PROBE;
                end
            end
            B_PROBE: state_next = B_ENTRY;
            B_ENTRY:
            begin
                if (slot_q == EW'(0))
                begin
                    state_next = B_MISS;
                end
                else if (ent_ok)
                begin
                    state_next = B_CMP;
                end
                else
                begin
                    state_next = probe_done ? B_MISS : B_PROBE;
                end
            end
            B_CMP:
            begin
                if (start_eq)
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    state_next = probe_done ? B_MISS : B_PROBE;
                end
            end
            B_MISS: state_next = B_OUT;
            B_OUT:
            begin
                if (out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == B_IDLE) && !q_empty;
        out_valid = (state_reg == B_OUT);
        out_data  = res_reg;
    end

    always_comb
    begin
        clr_next        = clr_reg;
        w_next          = w_reg;
        slot_next       = slot_reg;
        n_next          = n_reg;
        have_empty_next = have_empty_reg;
        empty_next      = empty_reg;
        bi_next         = bi_reg;
        used_next       = used_reg;
        tbytes_next     = tbytes_reg;
        tfiles_next     = tfiles_reg;
        full_next       = full_reg;
        res_next        = res_reg;
        slot_we         = 1'b0;
        slot_wa         = slot_reg;
        slot_wd         = EW'(0);
        bkt_we          = 1'b0;
        bkt_wa          = bi_reg;
        start_wd        = w_reg.start;
        bytes_wd        = hit_bytes;
        files_wd        = hit_files;
        case (state_reg)
            B_CLEAR:
            begin
                slot_we  = 1'b1;
                slot_wa  = clr_reg;
                clr_next = clr_reg + SW'(1);
            end
            B_IDLE:
            begin
                w_next          = q_data;
                slot_next       = SW'(q_data.slot);
                n_next          = NW'(0);
                have_empty_next = 1'b0;
                res_next        = '{status: STATUS_FILTERED, bucket_index: 7'd0,
                                    bucket_start: 63'd0, bucket_bytes: 64'd0,
                                    bucket_files: 32'd0, grand_bytes: tbytes_reg,
                                    grand_files: tfiles_reg, full_seen: full_reg};
            end
            B_ENTRY:
            begin
                bi_next = rd_bi;
                if (slot_q == EW'(0))
                begin
                    have_empty_next = 1'b1;
                    empty_next      = slot_reg;
                end
                else if (!ent_ok)
                begin
                    n_next    = n_inc;
                    slot_next = slot_inc;
                end
            end
            B_CMP:
            begin
                if (start_eq)
                begin
                    bkt_we      = 1'b1;
                    tbytes_next = tbytes_reg + w_reg.size;
                    tfiles_next = tfiles_inc;
                    res_next    = '{status: STATUS_HIT, bucket_index: 7'(bi_reg),
                                    bucket_start: w_reg.start, bucket_bytes: hit_bytes,
                                    bucket_files: hit_files,
                                    grand_bytes: tbytes_reg + w_reg.size,
                                    grand_files: tfiles_inc, full_seen: full_reg};
                end
                else
                begin
                    n_next    = n_inc;
                    slot_next = slot_inc;
                end
            end
            B_MISS:
            begin
                if (no_room)
                begin
                    full_next = 1'b1;
                    res_next  = '{status: STATUS_FULL, bucket_index: 7'd0,
                                  bucket_start: 63'd0, bucket_bytes: 64'd0,
                                  bucket_files: 32'd0, grand_bytes: tbytes_reg,
                                  grand_files: tfiles_reg, full_seen: 1'b1};
                end
                else
                begin
                    // append a bucket and link it from the empty slot
                    slot_we     = 1'b1;
                    slot_wa     = empty_reg;
                    slot_wd     = used_reg + EW'(1);
                    bkt_we      = 1'b1;
                    bkt_wa      = BW'(used_reg);
                    bytes_wd    = w_reg.size;
                    files_wd    = 32'd1;
                    used_next   = used_reg + EW'(1);
                    tbytes_next = tbytes_reg + w_reg.size;
                    tfiles_next = tfiles_inc;
                    res_next    = '{status: STATUS_NEW, bucket_index: 7'(used_reg),
                                    bucket_start: w_reg.start, bucket_bytes: w_reg.size,
                                    bucket_files: 32'd1,
                                    grand_bytes: tbytes_reg + w_reg.size,
                                    grand_files: tfiles_inc, full_seen: full_reg};
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLEAR;
            clr_reg    <= '0;
            used_reg   <= '0;
            tbytes_reg <= 64'd0;
            tfiles_reg <= 32'd0;
            full_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            used_reg   <= used_next;
            tbytes_reg <= tbytes_next;
            tfiles_reg <= tfiles_next;
            full_reg   <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        slot_reg       <= slot_next;
        n_reg          <= n_next;
        have_empty_reg <= have_empty_next;
        empty_reg      <= empty_next;
        bi_reg         <= bi_next;
        res_reg        <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_q <= slot_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            start_mem[bkt_wa] <= start_wd;
            bytes_mem[bkt_wa] <= bytes_wd;
            files_mem[bkt_wa] <= files_wd;
        end
        start_q <= start_mem[rd_bi];
        bytes_q <= bytes_mem[rd_bi];
        files_q <= files_mem[rd_bi];
    end

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= 32'(BUCKETS))
        else $error("bucket count beyond capacity");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("full flag cleared");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !pop)
        else $error("request taken during slot table clear");

    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> (res_reg.status == STATUS_NEW))
        else $error("bucket count changed without a new bucket");
`endif

endmodule

// ===== hw/rtl/hashed_time_bucket_accumulator_core.sv =====
// channel  direction  handshake             payload
// cfg      in         cfg_we                cfg_index, cfg_data
// in       in         in_valid / in_ready   in_data (stamp, file_size)
// out      out        out_valid / out_ready out_data (status .. full_seen)
//
// Front: filtered records skip to the push; else fold, quot, sub round the timestamp by
// chunk folding and a reciprocal multiply, then SplitMix64 on one shared 32x32 multiplier.
// Back: probe, entry, compare per probed slot; slot table has a read port and a write port.
// After reset the back clears every slot of the slot table; records queue meanwhile.
// A two-entry queue between front and back lets either side stall alone.
module hashed_time_bucket_accumulator_core
    import htba_pkg::*;
#(
    parameter int SLOTS   = 256,
    parameter int BUCKETS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [62:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  rec_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rec_out_t    out_data
);

    logic        mode_reg, mode_next;
    logic [62:0] cutoff_reg, cutoff_next;

    qctl_t qctl;
    work_t front_work;
    work_t q_data;
    logic  q_full;
    logic  q_empty;
    logic  pop;

    always_comb
    begin
        mode_next   = mode_reg;
        cutoff_next = cutoff_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERVAL_MODE: mode_next = cfg_data[0];
                CFG_CUTOFF_TIME:   cutoff_next = cfg_data;
                default:           mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            cutoff_reg <= 63'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            cutoff_reg <= cutoff_next;
        end
    end

    htba_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .interval_mode (mode_reg),
        .cutoff        (cutoff_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .q_full        (q_full),
        .qctl          (qctl),
        .work          (front_work)
    );

    htba_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .qctl      (qctl),
        .push_data (front_work),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    htba_back #(
        .SLOTS   (SLOTS),
        .BUCKETS (BUCKETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
